FILE: sv/sliding_window_min_max_top_defines.svh
// Assertion macros shared by the sliding window min/max RTL
`ifndef SLIDING_WINDOW_MIN_MAX_TOP_DEFINES_SVH
`define SLIDING_WINDOW_MIN_MAX_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define SWMM_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define SWMM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/swmm_pkg.sv
// Shared constants and types for the sliding window min/max block
package swmm_pkg;

    localparam int WINDOW_MAX_DEF  = 1024;
    localparam int SAMPLE_BITS_DEF = 32;
    localparam int CFG_BITS        = 11;
    localparam int MID_DEPTH       = 4;
    localparam int RES_DEPTH       = 2;

    typedef struct packed {
        logic restart;
        logic due;
    } swmm_ctrl_t;

endpackage

FILE: sv/sliding_window_min_max_top.sv
// Sliding window min/max: front end, item queue, deque back end, result queue.
// A sample passes the item queue, both deques (expire, tail pops, append), then the result queue.
// Each deque pops its tail as often as needed (at most once per sample on average); the next item
// starts once both are idle and any result fits; the deque store's registered read sets the pace.
// Reset (rst_n low, async): queues and deques empty, window size 1; the deque stores
// are not cleared and need no clearing pass, so samples are taken straight after reset.
module sliding_window_min_max_top
    import swmm_pkg::*;
#(
    parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          restart,
    input  logic                          window_size_we,
    input  logic        [CFG_BITS-1:0]    window_size,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [SAMPLE_BITS-1:0] window_min,
    output logic signed [SAMPLE_BITS-1:0] window_max
);

    localparam int POS_W = $clog2(2 * WINDOW_MAX);
    localparam int WIN_W = $clog2(WINDOW_MAX + 1);
    localparam int MID_W = SAMPLE_BITS + POS_W + $bits(swmm_ctrl_t);
    localparam int RES_W = 2 * SAMPLE_BITS;

    logic                          item_push;
    logic                          item_full;
    logic signed [SAMPLE_BITS-1:0] item_sample;
    logic        [POS_W-1:0]       item_now;
    swmm_ctrl_t                    item_ctrl;
    logic        [WIN_W-1:0]       win;

    logic                          q_empty;
    logic                          q_pop;
    logic        [MID_W-1:0]       q_data;
    logic signed [SAMPLE_BITS-1:0] q_sample;
    logic        [POS_W-1:0]       q_now;
    swmm_ctrl_t                    q_ctrl;

    logic                          res_full;
    logic                          res_push;
    logic signed [SAMPLE_BITS-1:0] res_min;
    logic signed [SAMPLE_BITS-1:0] res_max;
    logic        [RES_W-1:0]       res_data;

    assign {q_sample, q_now, q_ctrl} = q_data;
    assign {window_min, window_max}  = res_data;

    swmm_front #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS),
        .POS_W       (POS_W),
        .WIN_W       (WIN_W)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .sample         (sample),
        .restart        (restart),
        .window_size_we (window_size_we),
        .window_size    (window_size),
        .item_push      (item_push),
        .item_full      (item_full),
        .item_sample    (item_sample),
        .item_now       (item_now),
        .item_ctrl      (item_ctrl),
        .win            (win)
    );

    swmm_fifo #(
        .WIDTH (MID_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (item_push),
        .full  (item_full),
        .din   ({item_sample, item_now, item_ctrl}),
        .pop   (q_pop),
        .empty (q_empty),
        .dout  (q_data)
    );

    swmm_back #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS),
        .POS_W       (POS_W),
        .WIN_W       (WIN_W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (window_size_we),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .q_sample (q_sample),
        .q_now    (q_now),
        .q_ctrl   (q_ctrl),
        .win      (win),
        .res_full (res_full),
        .res_push (res_push),
        .res_min  (res_min),
        .res_max  (res_max)
    );

    swmm_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .full  (res_full),
        .din   ({res_min, res_max}),
        .pop   (pop),
        .empty (empty),
        .dout  (res_data)
    );

endmodule

FILE: sv/swmm_fifo.sv
// Small register queue with push/full and pop/empty sides
`include "sliding_window_min_max_top_defines.svh"

module swmm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] dout
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    `SWMM_ASSERT_NEXT(a_fifo_push_lands, do_push && !do_pop, !empty, "queue lost a pushed entry")

endmodule

FILE: sv/swmm_front.sv
// Front end: takes samples, stamps position and result-due flag
`include "sliding_window_min_max_top_defines.svh"

module swmm_front
    import swmm_pkg::*;
#(
    parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int POS_W       = $clog2(2 * WINDOW_MAX),
    parameter int WIN_W       = $clog2(WINDOW_MAX + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          restart,
    input  logic                          window_size_we,
    input  logic        [CFG_BITS-1:0]    window_size,
    output logic                          item_push,
    input  logic                          item_full,
    output logic signed [SAMPLE_BITS-1:0] item_sample,
    output logic        [POS_W-1:0]       item_now,
    output swmm_ctrl_t                    item_ctrl,
    output logic        [WIN_W-1:0]       win
);

    logic [WIN_W-1:0] win_reg, win_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [WIN_W-1:0] fill_reg, fill_next;
    logic [WIN_W-1:0] fill_base;
    logic             accept;

    assign accept      = push && !item_full;
    assign full        = item_full;
    assign item_push   = accept;
    assign item_sample = sample;
    assign item_now    = restart ? '0 : pos_reg;
    assign fill_base   = restart ? '0 : fill_reg;
    assign win         = win_reg;

    always_comb
    begin
        win_next  = win_reg;
        pos_next  = pos_reg;
        fill_next = fill_reg;
        if (window_size_we)
        begin
            // zero acts as one, oversize clamps to the store depth
            if (window_size == '0)
                win_next = WIN_W'(1);
            else if (32'(window_size) > 32'(WINDOW_MAX))
                win_next = WIN_W'(WINDOW_MAX);
            else
                win_next = WIN_W'(window_size);
            pos_next  = '0;
            fill_next = '0;
        end
        else if (accept)
        begin
            pos_next  = (item_now == POS_W'(2 * WINDOW_MAX - 1)) ? '0 : item_now + POS_W'(1);
            fill_next = (fill_base < WIN_W'(WINDOW_MAX)) ? fill_base + WIN_W'(1) : fill_base;
        end
    end

    always_comb
    begin
        item_ctrl.restart = restart;
        item_ctrl.due     = (fill_next >= win_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg  <= WIN_W'(1);
            pos_reg  <= '0;
            fill_reg <= '0;
        end
        else
        begin
            win_reg  <= win_next;
            pos_reg  <= pos_next;
            fill_reg <= fill_next;
        end
    end

    `SWMM_ASSERT(a_restart_due, accept && restart && !window_size_we, item_ctrl.due == (win_reg == WIN_W'(1)), "restart item due flag wrong")

endmodule

FILE: sv/swmm_deque.sv
// Monotonic deque unit: expire, tail pops and append over a 2-read 1-write store
`include "sliding_window_min_max_top_defines.svh"

module swmm_deque
    import swmm_pkg::*;
#(
    parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int POS_W       = $clog2(2 * WINDOW_MAX),
    parameter int WIN_W       = $clog2(WINDOW_MAX + 1),
    parameter bit IS_MAX      = 1'b0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clear,
    input  logic                          start,
    input  logic                          restart,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic        [POS_W-1:0]       now,
    input  logic        [WIN_W-1:0]       win,
    output logic                          busy,
    output logic signed [SAMPLE_BITS-1:0] head_value
);

    localparam int IDX_W = $clog2(WINDOW_MAX);
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int ENT_W = POS_W + SAMPLE_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXP,
        S_POP
    } state_t;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(WINDOW_MAX - 1)) ? '0 : i + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(WINDOW_MAX - 1) : i - IDX_W'(1);
    endfunction

    state_t                  state_reg, state_next;
    logic [IDX_W-1:0]        head_reg, head_next;
    logic [IDX_W-1:0]        tail_reg, tail_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [POS_W-1:0]        hpos_reg, hpos_next;
    logic signed [SAMPLE_BITS-1:0] hval_reg, hval_next;
    logic signed [SAMPLE_BITS-1:0] v_reg, v_next;
    logic [POS_W-1:0]        now_reg, now_next;

    logic [ENT_W-1:0]        mem [WINDOW_MAX];
    logic [ENT_W-1:0]        rd_a_q, rd_b_q;
    logic [IDX_W-1:0]        rd_a_addr, rd_b_addr;
    logic                    wr_en;

    logic [IDX_W-1:0]        head_s, tail_s;
    logic [CNT_W-1:0]        count_s;
    logic [CNT_W-1:0]        cnt_live;
    logic [POS_W:0]          age;
    logic                    expire;
    logic                    drop;
    logic signed [SAMPLE_BITS-1:0] tail_val;
    logic [POS_W-1:0]        next_head_pos;
    logic signed [SAMPLE_BITS-1:0] next_head_val;

    assign head_s        = restart ? '0 : head_reg;
    assign tail_s        = restart ? '0 : tail_reg;
    assign count_s       = restart ? '0 : count_reg;
    assign tail_val      = rd_b_q[SAMPLE_BITS-1:0];
    assign next_head_pos = rd_a_q[ENT_W-1 -: POS_W];
    assign next_head_val = rd_a_q[SAMPLE_BITS-1:0];
    // position distance modulo twice the store depth
    assign age = (now_reg >= hpos_reg)
               ? {1'b0, now_reg} - {1'b0, hpos_reg}
               : {1'b0, now_reg} + (POS_W+1)'(2 * WINDOW_MAX) - {1'b0, hpos_reg};

    assign busy       = (state_reg != S_IDLE);
    assign head_value = hval_reg;

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        hpos_next  = hpos_reg;
        hval_next  = hval_reg;
        v_next     = v_reg;
        now_next   = now_reg;
        rd_a_addr  = idx_inc(head_reg);
        rd_b_addr  = idx_dec(tail_reg);
        wr_en      = 1'b0;
        cnt_live   = count_reg;
        expire     = 1'b0;
        drop       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    head_next  = head_s;
                    tail_next  = tail_s;
                    count_next = count_s;
                    v_next     = sample;
                    now_next   = now;
                    rd_a_addr  = idx_inc(head_s);
                    rd_b_addr  = idx_dec(tail_s);
                    state_next = S_EXP;
                end
            end
            S_EXP, S_POP:
            begin
                if (state_reg == S_EXP)
                begin
                    expire   = (count_reg != '0) && (age >= (POS_W+1)'(win));
                    cnt_live = count_reg - CNT_W'(expire);
                    if (expire)
                    begin
                        head_next = idx_inc(head_reg);
                        hpos_next = next_head_pos;
                        hval_next = next_head_val;
                    end
                end
                // equal values count as no better, so the newer sample wins
                if (IS_MAX)
                    drop = (cnt_live != '0) && (tail_val <= v_reg);
                else
                    drop = (cnt_live != '0) && (tail_val >= v_reg);
                if (drop)
                begin
                    tail_next  = idx_dec(tail_reg);
                    count_next = cnt_live - CNT_W'(1);
                    rd_b_addr  = idx_dec(idx_dec(tail_reg));
                    state_next = S_POP;
                end
                else
                begin
                    wr_en      = 1'b1;
                    tail_next  = idx_inc(tail_reg);
                    count_next = cnt_live + CNT_W'(1);
                    if (cnt_live == '0)
                    begin
                        hpos_next = now_reg;
                        hval_next = v_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (clear)
        begin
            state_next = S_IDLE;
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
            wr_en      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            hpos_reg  <= '0;
            hval_reg  <= '0;
            v_reg     <= '0;
            now_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            hpos_reg  <= hpos_next;
            hval_reg  <= hval_next;
            v_reg     <= v_next;
            now_reg   <= now_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[tail_reg] <= {now_reg, v_reg};
        end
        rd_a_q <= mem[rd_a_addr];
        rd_b_q <= mem[rd_b_addr];
    end

    `SWMM_ASSERT(a_count_bound, 1'b1, count_reg <= CNT_W'(WINDOW_MAX), "deque overfilled")
    `SWMM_ASSERT_NEXT(a_append_live, busy && state_next == S_IDLE && !clear, count_reg != '0, "deque empty after append")

endmodule

FILE: sv/swmm_back.sv
// Back end: runs both deque units per item and hands results to the output queue
module swmm_back
    import swmm_pkg::*;
#(
    parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int POS_W       = $clog2(2 * WINDOW_MAX),
    parameter int WIN_W       = $clog2(WINDOW_MAX + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clear,
    input  logic                          q_empty,
    output logic                          q_pop,
    input  logic signed [SAMPLE_BITS-1:0] q_sample,
    input  logic        [POS_W-1:0]       q_now,
    input  swmm_ctrl_t                    q_ctrl,
    input  logic        [WIN_W-1:0]       win,
    input  logic                          res_full,
    output logic                          res_push,
    output logic signed [SAMPLE_BITS-1:0] res_min,
    output logic signed [SAMPLE_BITS-1:0] res_max
);

    logic busy_reg, busy_next;
    logic due_reg, due_next;
    logic min_busy, max_busy;
    logic finishing;
    logic start;

    // both units idle again means the item's appends have landed
    assign finishing = busy_reg && !min_busy && !max_busy && (!due_reg || !res_full);
    assign start     = (!busy_reg || finishing) && !q_empty;
    assign q_pop     = start;
    assign res_push  = finishing && due_reg;

    always_comb
    begin
        busy_next = busy_reg;
        due_next  = due_reg;
        if (start)
        begin
            busy_next = 1'b1;
            due_next  = q_ctrl.due;
        end
        else if (finishing)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            due_reg  <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            due_reg  <= due_next;
        end
    end

    swmm_deque #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS),
        .POS_W       (POS_W),
        .WIN_W       (WIN_W),
        .IS_MAX      (1'b0)
    ) u_min (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (clear),
        .start      (start),
        .restart    (q_ctrl.restart),
        .sample     (q_sample),
        .now        (q_now),
        .win        (win),
        .busy       (min_busy),
        .head_value (res_min)
    );

    swmm_deque #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS),
        .POS_W       (POS_W),
        .WIN_W       (WIN_W),
        .IS_MAX      (1'b1)
    ) u_max (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (clear),
        .start      (start),
        .restart    (q_ctrl.restart),
        .sample     (q_sample),
        .now        (q_now),
        .win        (win),
        .busy       (max_busy),
        .head_value (res_max)
    );

endmodule
